### rtl/core/ssfd_pkg.sv
// Shared types, constants and arithmetic helpers for the stiff string step unit.
`timescale 1ns / 1ps
package ssfd_pkg;

	localparam int MAX_POINTS = 256;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int FIRST_POINT = 2;
	localparam int COEF_W = 31;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int ROUND_SHIFT = 29;

	localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_SQ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MU_SQ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_COEF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_NORM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOSS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_INDEX = 3'd6;

	localparam logic [COEF_W-1:0] LAMBDA_SQ_RST = 31'd268435456;
	localparam logic [COEF_W-1:0] INV_NORM_RST = 31'd536870912;
	localparam logic [7:0] NUM_POINTS_RST = 8'd100;
	localparam logic [7:0] OUT_INDEX_RST = 8'd50;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef logic signed [DATA_W-1:0] sample_t;

	typedef struct packed {
		logic [COEF_W-1:0] lambda_sq;
		logic [COEF_W-1:0] mu_sq;
		logic [COEF_W-1:0] loss_coef;
		logic [COEF_W-1:0] inv_norm;
		logic [COEF_W-1:0] freq_loss_coef;
		logic [7:0] num_points;
		logic [7:0] out_index;
	} cfg_t;

	function automatic sample_t sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Rounded Q2.29 product: arithmetic shift of product plus half rounds to nearest, ties upward.
	function automatic logic signed [34:0] qround(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd268435456) >>> ROUND_SHIFT;
		return t[34:0];
	endfunction

endpackage

### rtl/core/ssfd_bank_ram.sv
// One displacement bank: synchronous RAM with one write and one registered read port.
`timescale 1ns / 1ps
module ssfd_bank_ram (
	input  logic clk,
	input  logic we,
	input  logic [ssfd_pkg::IDX_W-1:0] waddr,
	input  ssfd_pkg::sample_t wdata,
	input  logic [ssfd_pkg::IDX_W-1:0] raddr,
	output ssfd_pkg::sample_t rdata
);
	import ssfd_pkg::*;

	sample_t mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/ssfd_point_dp.sv
// Pipelined per-point update arithmetic over a five-point window.
`timescale 1ns / 1ps
module ssfd_point_dp (
	input  logic clk,
	input  ssfd_pkg::cfg_t cfg,
	input  ssfd_pkg::sample_t cm2,
	input  ssfd_pkg::sample_t cm,
	input  ssfd_pkg::sample_t c0,
	input  ssfd_pkg::sample_t cp,
	input  ssfd_pkg::sample_t cp2,
	input  ssfd_pkg::sample_t pm,
	input  ssfd_pkg::sample_t p0,
	input  ssfd_pkg::sample_t pp,
	output ssfd_pkg::sample_t result
);
	import ssfd_pkg::*;

	sample_t d2c_s1, d2p_s1, d4_s1, c0_s1, p0_s1;
	logic signed [34:0] ml_s2;
	sample_t c0_s2, p0_s2, d4_s2, dd_s2;
	sample_t w_s3, d4_s3, p0_s3, dd_s3;
	logic signed [34:0] mi_s4, mm_s4, ml_s4, mf_s4;

	always_ff @(posedge clk) begin
		d2c_s1 <= sat32(40'(cm) - 40'(c0) * 2 + 40'(cp));
		d2p_s1 <= sat32(40'(pm) - 40'(p0) * 2 + 40'(pp));
		d4_s1 <= sat32(40'(cp2) - 40'(cp) * 4 + 40'(c0) * 6 - 40'(cm) * 4 + 40'(cm2));
		c0_s1 <= c0;
		p0_s1 <= p0;

		ml_s2 <= qround($signed({33'd0, cfg.lambda_sq}) * 64'(d2c_s1));
		c0_s2 <= c0_s1;
		p0_s2 <= p0_s1;
		d4_s2 <= d4_s1;
		dd_s2 <= sat32(40'(d2c_s1) - 40'(d2p_s1));

		w_s3 <= sat32(40'(c0_s2) * 2 - 40'(p0_s2) + 40'(ml_s2));
		d4_s3 <= d4_s2;
		p0_s3 <= p0_s2;
		dd_s3 <= dd_s2;

		mi_s4 <= qround($signed({33'd0, cfg.inv_norm}) * 64'(w_s3));
		mm_s4 <= qround($signed({33'd0, cfg.mu_sq}) * 64'(d4_s3));
		ml_s4 <= qround($signed({33'd0, cfg.loss_coef}) * 64'(p0_s3));
		mf_s4 <= qround($signed({33'd0, cfg.freq_loss_coef}) * 64'(dd_s3));

		result <= sat32(40'(mi_s4) - 40'(mm_s4) + 40'(ml_s4) + 40'(mf_s4));
	end
endmodule

### rtl/core/stiff_string_fdtd_step_unit.sv
// Top level of the stiff string finite-difference step unit.
// Channels: in_valid/in_ready carry one item (func, point_index, point_value);
// out_valid/out_ready carry one sample per tick item. Configuration is a plain
// write port (cfg_we, cfg_index, cfg_data) that the user must use only while the
// unit is idle; the block does not enforce this. A write item stores one value
// into the current and previous banks and yields no beat. A tick item streams
// points two through N-2 through a five-stage datapath, one point per cycle,
// reading the current and previous banks and writing the next bank. The beat is
// offered after three steps: a sweep of reads through the single read port of
// each bank, a drain of the datapath, and a read of the sample at out_index
// into an output register. Items are taken one at a time; a new item is accepted
// in the cycle after the tick's beat has left the output register, and a stalled
// receiver holds the unit. Reset clears the banks by sweeping all 256 entries,
// one per cycle, while no item is accepted; configuration registers return to
// their defaults and the rotation to zero at once.
`timescale 1ns / 1ps
module stiff_string_fdtd_step_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	input  logic [7:0] point_index,
	input  logic signed [31:0] point_value,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] sample,
	input  logic cfg_we,
	input  logic [ssfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [30:0] cfg_data
);
	import ssfd_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RUN = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;
	localparam int LAT = 5;

	cfg_t cfg_q;
	logic [2:0] state_q;
	logic [1:0] rot_q;
	logic [IDX_W:0] rd_q;
	logic [IDX_W-1:0] clr_q;
	logic [3:0] drain_q;
	logic [LAT-1:0] vld_q;
	logic [IDX_W-1:0] wa_q [LAT];
	sample_t c_q [5];
	sample_t p_q [4];
	sample_t out_q;
	logic [IDX_W:0] n_last;
	logic [1:0] b_nxt, b_cur, b_prv;
	logic [IDX_W-1:0] raddr;
	sample_t rdat [3];
	logic we [3];
	logic [IDX_W-1:0] waddr [3];
	sample_t wdata [3];
	sample_t dp_res;
	sample_t rd_cur, rd_prv, rd_nxt;
	logic pt_issue;

	assign n_last = {1'b0, cfg_q.num_points};
	assign b_nxt = rot_q;
	assign b_cur = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
	assign b_prv = (rot_q == 2'd0) ? 2'd2 : rot_q - 2'd1;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign sample = out_q;

	assign pt_issue = (state_q == ST_RUN) && (rd_q >= 9'(FIRST_POINT + 4)) &&
		(rd_q <= n_last + 9'd2);

	always_comb begin
		raddr = rd_q[IDX_W-1:0];
		if (state_q == ST_DRAIN) begin
			raddr = cfg_q.out_index;
		end
		rd_cur = rdat[b_cur];
		rd_prv = rdat[b_prv];
		rd_nxt = rdat[b_nxt];
		for (int b = 0; b < 3; b++) begin
			we[b] = 1'b0;
			waddr[b] = wa_q[LAT-1];
			wdata[b] = dp_res;
			if (state_q == ST_CLEAR) begin
				we[b] = 1'b1;
				waddr[b] = clr_q;
				wdata[b] = '0;
			end else if (in_valid && in_ready && func == FUNC_WRITE) begin
				we[b] = (2'(b) != b_nxt);
				waddr[b] = point_index;
				wdata[b] = point_value;
			end else if (vld_q[LAT-1]) begin
				we[b] = (2'(b) == b_nxt);
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_bank
		ssfd_bank_ram u_bank (
			.clk(clk), .we(we[g]), .waddr(waddr[g]), .wdata(wdata[g]),
			.raddr(raddr), .rdata(rdat[g])
		);
	end

	ssfd_point_dp u_dp (
		.clk(clk), .cfg(cfg_q),
		.cm2(c_q[4]), .cm(c_q[3]), .c0(c_q[2]), .cp(c_q[1]), .cp2(c_q[0]),
		.pm(p_q[3]), .p0(p_q[2]), .pp(p_q[1]),
		.result(dp_res)
	);

	// Window shift: a bank read passes the RAM read register and then c_q[0]/p_q[0],
	// so while rd_q is l+4 the window is centered on l.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN || state_q == ST_DRAIN) begin
			c_q[0] <= rd_cur;
			p_q[0] <= rd_prv;
			for (int i = 1; i < 5; i++) c_q[i] <= c_q[i-1];
			for (int i = 1; i < 4; i++) p_q[i] <= p_q[i-1];
		end
		wa_q[0] <= 8'(rd_q - 9'd4);
		for (int i = 1; i < LAT; i++) wa_q[i] <= wa_q[i-1];
		if (state_q == ST_READ) begin
			out_q <= rd_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			rot_q <= '0;
			rd_q <= '0;
			clr_q <= '0;
			drain_q <= '0;
			vld_q <= '0;
			cfg_q <= '{LAMBDA_SQ_RST, '0, '0, INV_NORM_RST, '0, NUM_POINTS_RST, OUT_INDEX_RST};
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LAMBDA_SQ: cfg_q.lambda_sq <= cfg_data;
					REG_MU_SQ: cfg_q.mu_sq <= cfg_data;
					REG_LOSS_COEF: cfg_q.loss_coef <= cfg_data;
					REG_INV_NORM: cfg_q.inv_norm <= cfg_data;
					REG_FREQ_LOSS: cfg_q.freq_loss_coef <= cfg_data;
					REG_NUM_POINTS: cfg_q.num_points <= cfg_data[7:0];
					REG_OUT_INDEX: cfg_q.out_index <= cfg_data[7:0];
					default: ;
				endcase
			end
			vld_q <= {vld_q[LAT-2:0], pt_issue};
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(MAX_POINTS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					rd_q <= '0;
					if (in_valid && func == FUNC_TICK) state_q <= ST_RUN;
				end
				ST_RUN: begin
					rd_q <= rd_q + 1'b1;
					if (rd_q >= n_last + 9'd2) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end
				end
				ST_DRAIN: begin
					rd_q <= rd_q + 1'b1;
					drain_q <= drain_q + 1'b1;
					if (drain_q == 4'(LAT + 1)) state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
						rot_q <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample))
		else $error("output beat dropped or changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("input accepted while busy");
	a_no_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> !vld_q[LAT-1])
		else $error("bank write pending while beat is offered");
endmodule

### test/tb.sv
// Self-checking testbench for the stiff string step unit, with a string predictor and a sample scoreboard.
`timescale 1ns / 1ps
module tb;
	import ssfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	class sample_board;
		int signed banks[3][256];
		int unsigned rot;
		longint unsigned lam, mu, loss, inv, fl;
		int unsigned npts, oidx;
		int signed pending[$];
		int errors;
		int ticks;

		function void clear();
			foreach (banks[b, i]) banks[b][i] = 0;
			rot = 0;
			lam = LAMBDA_SQ_RST; mu = 0; loss = 0; inv = INV_NORM_RST; fl = 0;
			npts = NUM_POINTS_RST; oidx = OUT_INDEX_RST;
			errors = 0; ticks = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] v);
			case (idx)
				REG_LAMBDA_SQ: lam = v;
				REG_MU_SQ: mu = v;
				REG_LOSS_COEF: loss = v;
				REG_INV_NORM: inv = v;
				REG_FREQ_LOSS: fl = v;
				REG_NUM_POINTS: npts = v[7:0];
				REG_OUT_INDEX: oidx = v[7:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint qprod(longint unsigned c, longint x);
			longint p;
			p = longint'(c) * x + 64'sd268435456;
			return p >>> 29;
		endfunction

		function void note_item(logic f, logic [7:0] pi, logic signed [31:0] pv);
			int nb, cb, pb, n;
			longint c0, cm, cp, cm2, cp2, p0, pm, pp, d2c, d2p, d4, w, r;
			nb = rot % 3; cb = (rot + 1) % 3; pb = (rot + 2) % 3;
			if (f == FUNC_WRITE) begin
				banks[cb][pi] = pv;
				banks[pb][pi] = pv;
				return;
			end
			n = npts;
			for (int l = FIRST_POINT; l < n - 1; l++) begin
				c0 = banks[cb][l]; cm = banks[cb][l-1]; cp = banks[cb][l+1];
				cm2 = banks[cb][l-2]; cp2 = banks[cb][l+2];
				p0 = banks[pb][l]; pm = banks[pb][l-1]; pp = banks[pb][l+1];
				d2c = clamp(cm - 2 * c0 + cp);
				d2p = clamp(pm - 2 * p0 + pp);
				d4 = clamp(cp2 - 4 * cp + 6 * c0 - 4 * cm + cm2);
				w = clamp(2 * c0 - p0 + qprod(lam, d2c));
				r = qprod(inv, w) - qprod(mu, d4) + qprod(loss, p0)
					+ qprod(fl, clamp(d2c - d2p));
				banks[nb][l] = int'(clamp(r));
			end
			pending = {pending, banks[nb][oidx]};
			rot = (rot + 1) % 3;
		endfunction

		function void check_sample(logic signed [31:0] got);
			int signed want;
			if (pending.size() == 0) begin
				$error("sample: unexpected beat, actual %0d", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			ticks++;
			if (got !== want) begin
				$error("sample: expected %0d actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, func = 0, out_ready = 0, cfg_we = 0;
	logic [7:0] point_index = 0;
	logic signed [31:0] point_value = 0;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [30:0] cfg_data = 0;
	logic in_ready, out_valid;
	logic signed [31:0] sample;
	sample_board board;
	longint cycles = 0;
	int burst = 0;
	int stall_mode = 0;

	always #5 clk = ~clk;

	stiff_string_fdtd_step_unit u_dut (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && in_valid && in_ready) board.note_item(func, point_index, point_value);
		if (arst_n && out_valid && out_ready) board.check_sample(sample);
	end

	// The receiver stalls on a pattern chosen at random: never, often, or in long runs.
	always @(negedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 2) != 0);
			default: out_ready <= ((cycles / 37) % 3 != 0);
		endcase
		if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 2);
	end

	task automatic send_item(logic f, logic [7:0] pi, logic signed [31:0] pv);
		int gap;
		if (burst == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst = $urandom_range(1, 12);
		end
		burst--;
		in_valid <= 1'b1; func <= f; point_index <= pi; point_value <= pv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		board.set_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_value(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	task automatic random_setting(bit extreme);
		write_reg(REG_LAMBDA_SQ, 31'(extreme ? 31'h7fffffff : $urandom_range(0, 1 << 29)));
		write_reg(REG_MU_SQ, 31'(extreme ? 31'h7fffffff : $urandom_range(0, 1 << 26)));
		write_reg(REG_LOSS_COEF, 31'(extreme ? 31'h7fffffff : $urandom_range(0, 1 << 24)));
		write_reg(REG_INV_NORM,
			31'(extreme ? 31'h7fffffff : $urandom_range(1 << 28, 1 << 29)));
		write_reg(REG_FREQ_LOSS, 31'(extreme ? 31'h7fffffff : $urandom_range(0, 1 << 25)));
		write_reg(REG_NUM_POINTS, 31'(extreme ? 8'd255 : $urandom_range(0, 40)));
		write_reg(REG_OUT_INDEX, 31'($urandom_range(0, 255)));
		write_reg(REG_UNUSED, 31'($urandom));
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		// Directed: defaults, edges, extremes, tiny string, index 255.
		send_item(FUNC_WRITE, 8'd50, 32'sh7fffffff);
		send_item(FUNC_WRITE, 8'd0, 32'sh80000000);
		send_item(FUNC_WRITE, 8'd255, 32'sh12345678);
		send_item(FUNC_WRITE, 8'd99, -32'sd1);
		send_item(FUNC_TICK, 8'd0, 0);
		send_item(FUNC_TICK, 8'd255, -1);
		settle();
		random_setting(1);
		send_item(FUNC_WRITE, 8'd128, 32'sh80000000);
		send_item(FUNC_WRITE, 8'd129, 32'sh7fffffff);
		repeat (4) send_item(FUNC_TICK, 8'd0, 0);
		settle();
		write_reg(REG_NUM_POINTS, 8'd3);
		write_reg(REG_OUT_INDEX, 8'd0);
		send_item(FUNC_TICK, 8'd0, 0);
		settle();
		write_reg(REG_NUM_POINTS, 8'd5);
		write_reg(REG_OUT_INDEX, 8'd2);
		send_item(FUNC_WRITE, 8'd2, 32'sh4000000);
		send_item(FUNC_TICK, 8'd0, 0);
		send_item(FUNC_TICK, 8'd0, 0);
		settle();
		// Random phases: excitation writes mixed at random with ticks of random content.
		for (int ph = 0; ph < 24; ph++) begin
			random_setting(ph % 8 == 7);
			for (int k = 0; k < 75; k++) begin
				if ($urandom_range(0, 2) == 0)
					send_item(FUNC_TICK, 8'($urandom), 32'($urandom));
				else
					send_item(FUNC_WRITE,
						8'((ph % 8 == 7) ? $urandom : $urandom_range(0, 42)),
						rand_value($urandom_range(0, 3)));
			end
			settle();
		end
		$display("Checked %0d samples under the default, directed and 24 random settings,",
			board.ticks);
		$display("with random bursts of writes and ticks against a stalling receiver.");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
